// ===== sv/jss_pkg.sv =====
// Shared types and constants of the JTAG scan shifter.
`default_nettype none

package jss_pkg;

	// Item kinds carried in the slave-side tuser.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Register word index decoded from paddr[2].
	localparam logic CFG_IDX_HALF_PERIOD = 1'b0;

	localparam int HALF_PERIOD_W = 16;
	localparam int MAX_BITS      = 8;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOW  = 2'd1,
		PH_HIGH = 2'd2
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] tdi_byte;
		logic [3:0] bit_count;
		logic       tms_value;
		logic       exit_on_last;
		logic       tdo_pin;
	} item_t;

	typedef struct packed {
		logic       tck;
		logic       tdi;
		logic       tms;
		logic       busy_res;
		logic       tdo_valid;
		logic [7:0] tdo_byte;
		logic       load_rejected;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/jss_engine.sv =====
// Scan engine state and the per-beat next-state logic of the JTAG scan shifter.
`default_nettype none

module jss_engine #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire jss_pkg::item_t        item,
	input  wire logic [15:0]           half_period,
	output jss_pkg::result_t           result
);

	localparam logic [32:0] LIM = 33'(1) << TICK_COUNT_BITS;

	jss_pkg::phase_t             phase_q, phase_d;
	logic [TICK_COUNT_BITS-1:0]  tick_q, tick_d, tick_inc, len_mod;
	logic [2:0]                  bit_index_q, bit_index_d;
	logic [3:0]                  bits_total_q, bits_total_d, n_bits, next_pos;
	logic [7:0]                  out_shift_q, out_shift_d;
	logic [7:0]                  capture_q, capture_d, capture_new;
	logic                        tck_q, tck_d, tdi_q, tdi_d, tms_q, tms_d;
	logic                        exit_q, exit_d;
	logic [32:0]                 h_ext;

	// Phase length, with zero treated as one and clamped to the counter range.
	always_comb begin
		h_ext = {17'b0, half_period};
		if (h_ext == 33'd0) begin
			h_ext = 33'd1;
		end
		if (h_ext > LIM) begin
			h_ext = LIM;
		end
		len_mod = h_ext[TICK_COUNT_BITS-1:0];
	end

	assign tick_inc    = tick_q + TICK_COUNT_BITS'(1);
	assign n_bits      = (item.bit_count > 4'(jss_pkg::MAX_BITS)) ?
	                     4'(jss_pkg::MAX_BITS) : item.bit_count;
	assign next_pos    = {1'b0, bit_index_q} + 4'd1;
	assign capture_new = capture_q | (8'(item.tdo_pin) << bit_index_q);

	always_comb begin
		phase_d      = phase_q;
		tick_d       = tick_q;
		bit_index_d  = bit_index_q;
		bits_total_d = bits_total_q;
		out_shift_d  = out_shift_q;
		capture_d    = capture_q;
		tck_d        = tck_q;
		tdi_d        = tdi_q;
		tms_d        = tms_q;
		exit_d       = exit_q;
		result       = '0;

		if (item.op == jss_pkg::OP_LOAD) begin
			if (phase_q != jss_pkg::PH_IDLE) begin
				result.load_rejected = 1'b1;
			end else if (n_bits != 4'd0) begin
				out_shift_d  = item.tdi_byte;
				bits_total_d = n_bits;
				bit_index_d  = 3'd0;
				capture_d    = 8'd0;
				exit_d       = item.exit_on_last;
				tms_d        = (item.exit_on_last && n_bits == 4'd1) ? 1'b1 : item.tms_value;
				tck_d        = 1'b0;
				tdi_d        = item.tdi_byte[0];
				tick_d       = '0;
				phase_d      = jss_pkg::PH_LOW;
			end
		end else if (phase_q != jss_pkg::PH_IDLE) begin
			tick_d = tick_inc;
			if (tick_inc == len_mod) begin
				tick_d = '0;
				case (phase_q)
					jss_pkg::PH_LOW: begin
						tck_d   = 1'b1;
						phase_d = jss_pkg::PH_HIGH;
					end
					jss_pkg::PH_HIGH: begin
						capture_d = capture_new;
						tck_d     = 1'b0;
						if (next_pos >= bits_total_q) begin
							phase_d          = jss_pkg::PH_IDLE;
							result.tdo_valid = 1'b1;
							result.tdo_byte  = capture_new;
						end else begin
							// Set up the next bit; raise TMS ahead of the last one on exit.
							bit_index_d = next_pos[2:0];
							tdi_d       = out_shift_q[next_pos[2:0]];
							if (exit_q && (next_pos + 4'd1 == bits_total_q)) begin
								tms_d = 1'b1;
							end
							phase_d = jss_pkg::PH_LOW;
						end
					end
					default: begin
						phase_d = jss_pkg::PH_IDLE;
					end
				endcase
			end
		end

		result.tck      = tck_d;
		result.tdi      = tdi_d;
		result.tms      = tms_d;
		result.busy_res = (phase_d != jss_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= jss_pkg::PH_IDLE;
			tick_q       <= '0;
			bit_index_q  <= 3'd0;
			bits_total_q <= 4'd0;
			capture_q    <= 8'd0;
			tck_q        <= 1'b0;
			tdi_q        <= 1'b1;
			tms_q        <= 1'b1;
			exit_q       <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_q       <= tick_d;
			bit_index_q  <= bit_index_d;
			bits_total_q <= bits_total_d;
			capture_q    <= capture_d;
			tck_q        <= tck_d;
			tdi_q        <= tdi_d;
			tms_q        <= tms_d;
			exit_q       <= exit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_shift_q <= out_shift_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_valid_from_high: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.tdo_valid |-> phase_q == jss_pkg::PH_HIGH)
		else $error("captured byte reported outside a high phase");
	a_idle_tck_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == jss_pkg::PH_IDLE |-> !tck_q && tick_q == '0)
		else $error("TCK high or tick counter running while idle");
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != jss_pkg::PH_IDLE |-> bits_total_q != 4'd0 && bits_total_q <= 4'd8
		&& {1'b0, bit_index_q} < bits_total_q)
		else $error("bit index or bit total out of range while shifting");
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.load_rejected |=> $stable(phase_q) && $stable(bit_index_q)
		&& $stable(capture_q))
		else $error("rejected load changed the engine state");
`endif

endmodule

`default_nettype wire

// ===== sv/jtag_scan_shifter_core.sv =====
// Top level of the JTAG scan shifter: stream ports, result register and APB register.
//
// Channel   Direction  Beat content
// s_*       in         tdata: tdi_byte, bit_count, tms_value, exit_on_last, tdo_pin; tuser: op
// m_*       out        tdata: tck, tdi, tms, busy_res, tdo_valid, tdo_byte, load_rejected
// APB       in/out     register 0 at byte address 0: half_period_ticks (16 bits)
//
// Every input beat produces exactly one result beat, which appears in the cycle after acceptance.
// The engine state and the result register update in the same cycle, so a new beat
// is taken every cycle as long as the result register is empty or being drained.
// A stall on the master side holds the result and stops acceptance until it is taken.
// Reset puts TCK low, TDI and TMS high, the engine idle and the half period at one tick.
`default_nettype none

module jtag_scan_shifter_core #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] tdi_byte, [11:8] bit_count, [12] tms_value, [13] exit_on_last,
	// [14] tdo_pin, [15] zero
	input  wire logic [15:0] s_tdata,
	// [0] op
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] tck, [1] tdi, [2] tms, [3] busy_res, [4] tdo_valid, [12:5] tdo_byte,
	// [13] load_rejected, [15:14] zero
	output logic [15:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	jss_pkg::item_t   item;
	jss_pkg::result_t result, res_q;
	logic             accept;
	logic             out_valid_q;
	logic [15:0]      half_period_q;
	logic             cfg_hit;

	// The address decode ignores the byte offset within the word.
	assign cfg_hit = (paddr[2] == jss_pkg::CFG_IDX_HALF_PERIOD);
	assign pready  = 1'b1;
	assign prdata  = cfg_hit ? {16'b0, half_period_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= 16'd1;
		end else if (psel && penable && pwrite && cfg_hit) begin
			half_period_q <= pwdata[15:0];
		end
	end

	// Unpack the input beat.
	assign item.op           = s_tuser;
	assign item.tdi_byte     = s_tdata[7:0];
	assign item.bit_count    = s_tdata[11:8];
	assign item.tms_value    = s_tdata[12];
	assign item.exit_on_last = s_tdata[13];
	assign item.tdo_pin      = s_tdata[14];

	// The result register is the only buffer: accept whenever it can take a new beat.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	jss_engine #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.item       (item),
		.half_period(half_period_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.load_rejected, res_q.tdo_byte, res_q.tdo_valid,
	                   res_q.busy_res, res_q.tms, res_q.tdi, res_q.tck};

endmodule

`default_nettype wire
